// ----- sv/bmon_pkg.sv -----
// Shared types and constants for the battery monitor.
// Used by bmon_div and battery_monitor_state_machine; depends on nothing.
`timescale 1ns / 1ps

package bmon_pkg;

  // Field and internal widths
  localparam int VOLT_W  = 12;
  localparam int STAT_W  = 3;
  localparam int CELL_W  = 4;
  localparam int LIM_W   = 14;
  localparam int CMP_W   = 15;
  localparam int CFG_W   = 12;
  localparam int IDX_W   = 3;

  // Shared divider geometry: 24-bit dividend covers 4095*3300, 16-bit divisor
  localparam int DIV_DW  = 24;
  localparam int DIV_VW  = 16;
  localparam int ITER_W  = 5;

  localparam logic [VOLT_W-1:0] VOLT_MAX   = 12'hFFF;
  localparam logic [11:0]       VOLT_SCALE = 12'd3300;

  // Battery status codes
  localparam logic [STAT_W-1:0] ST_ABSENT   = 3'd0;
  localparam logic [STAT_W-1:0] ST_OK       = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STAT_W-1:0] ST_WARNING  = 3'd3;
  localparam logic [STAT_W-1:0] ST_CRITICAL = 3'd4;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_CELL_MAX  = 3'd0;
  localparam logic [IDX_W-1:0] REG_CELL_WARN = 3'd1;
  localparam logic [IDX_W-1:0] REG_CELL_MIN  = 3'd2;
  localparam logic [IDX_W-1:0] REG_PRESENT   = 3'd3;
  localparam logic [IDX_W-1:0] REG_HYST      = 3'd4;
  localparam logic [IDX_W-1:0] REG_MARGIN    = 3'd5;

  // Configuration reset values
  localparam logic [9:0]  RST_CELL_MAX  = 10'd424;
  localparam logic [9:0]  RST_CELL_WARN = 10'd350;
  localparam logic [9:0]  RST_CELL_MIN  = 10'd330;
  localparam logic [11:0] RST_PRESENT   = 12'd100;
  localparam logic [7:0]  RST_HYST      = 8'd10;
  localparam logic [7:0]  RST_MARGIN    = 8'd14;

  // Divider control and status
  typedef struct packed {
    logic              start;
    logic [ITER_W-1:0] iters;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- sv/bmon_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by the monitor.
// Depends on bmon_pkg for widths and the control/status structs.
`timescale 1ns / 1ps

module bmon_div (
  input  logic                      clk,
  input  logic                      rst,
  input  bmon_pkg::div_ctrl_t       ctrl,
  input  logic [bmon_pkg::DIV_DW-1:0] dividend,
  input  logic [bmon_pkg::DIV_VW-1:0] divisor,
  output logic [bmon_pkg::DIV_DW-1:0] quotient,
  output bmon_pkg::div_stat_t       stat
);

  logic [bmon_pkg::ITER_W-1:0] count;
  logic                        done;
  logic [bmon_pkg::DIV_DW-1:0] num;
  logic [bmon_pkg::DIV_VW-1:0] den;
  logic [bmon_pkg::DIV_VW-1:0] rem;
  logic [bmon_pkg::DIV_DW-1:0] quot;

  logic [bmon_pkg::DIV_VW:0]   trial;
  logic [bmon_pkg::DIV_VW:0]   diff;
  logic                        ge;
  logic [bmon_pkg::DIV_VW-1:0] rem_next;

  // One trial subtraction per cycle, dividend consumed MSB first
  always_comb begin
    trial    = {rem, num[bmon_pkg::DIV_DW-1]};
    diff     = trial - {1'b0, den};
    ge       = (trial >= {1'b0, den});
    rem_next = ge ? diff[bmon_pkg::DIV_VW-1:0] : trial[bmon_pkg::DIV_VW-1:0];
  end

  // Iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= (count == bmon_pkg::ITER_W'(1)) && !ctrl.start;
      if (ctrl.start) begin
        count <= ctrl.iters;
      end else if (count != '0) begin
        count <= count - 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      num  <= dividend;
      den  <= divisor;
      rem  <= '0;
      quot <= '0;
    end else if (count != '0) begin
      num  <= {num[bmon_pkg::DIV_DW-2:0], 1'b0};
      rem  <= rem_next;
      quot <= {quot[bmon_pkg::DIV_DW-2:0], ge};
    end
  end

  assign quotient  = quot;
  assign stat.busy = (count != '0);
  assign stat.done = done;

  // Checks
  a_load: assert property (@(posedge clk) disable iff (rst)
    ctrl.start |=> count == $past(ctrl.iters))
    else $error("divider did not load iteration count");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> count == '0)
    else $error("divider done while still iterating");

  a_countdown: assert property (@(posedge clk) disable iff (rst)
    (count != '0 && !ctrl.start) |=> count == $past(count) - 1'b1)
    else $error("divider count skipped");

endmodule

// ----- sv/battery_monitor_state_machine.sv -----
// Battery voltage monitor with hysteresis: top level.
// Depends on bmon_pkg and bmon_div.
`timescale 1ns / 1ps

// Each request carries one raw ADC sample. The block converts it to volts
// (0.01 V units) as sample*3300/ADC_FULL_SCALE, detects the cell count when a
// pack is first seen above present_threshold, and steps an ok/full/warning/
// critical state machine with hysteresis. Both divisions run on one shared
// restoring divider at one quotient bit per cycle. A sample passes through the
// voltage division, the decide step, the evaluate step and the output step.
// When a pack is being connected, the 12-bit cell-count division and the
// limit and flag steps come between decide and evaluate; a connect with a
// zero cell_max_voltage skips the division. The next sample can be accepted
// the cycle after a result is registered. One sample is worked on at a time;
// the next can be accepted while the previous result still waits in the
// output register, and the sequencer holds in its last step until that
// register is free. Configuration writes take effect at once and are meant
// to be done while the block is idle.
module battery_monitor_state_machine #(
  parameter int MAX_CELLS      = 8,
  parameter int ADC_FULL_SCALE = 4095
) (
  input  logic                            clk,
  input  logic                            rst,
  // sample channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [11:0]                     raw_sample,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bmon_pkg::VOLT_W-1:0]     battery_voltage,
  output logic [bmon_pkg::STAT_W-1:0]     battery_status,
  output logic [bmon_pkg::CELL_W-1:0]     cells_detected,
  output logic                            full_at_connect,
  // configuration
  input  logic                            cfg_we,
  input  logic [bmon_pkg::IDX_W-1:0]      cfg_index,
  input  logic [bmon_pkg::CFG_W-1:0]      cfg_data
);

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_VDIV   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_CDIV   = 3'd3;
  localparam logic [2:0] S_LIM    = 3'd4;
  localparam logic [2:0] S_FLAG   = 3'd5;
  localparam logic [2:0] S_EVAL   = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  localparam logic [bmon_pkg::CELL_W-1:0] CELLS_SAT = bmon_pkg::CELL_W'(MAX_CELLS);
  localparam logic [bmon_pkg::DIV_VW-1:0] FS_DIV    = bmon_pkg::DIV_VW'(ADC_FULL_SCALE);

  logic [2:0] state;

  // Configuration registers
  logic [9:0]  cell_max_voltage;
  logic [9:0]  cell_warning_voltage;
  logic [9:0]  cell_min_voltage;
  logic [11:0] present_threshold;
  logic [7:0]  hysteresis;
  logic [7:0]  full_margin_per_cell;

  // Architectural state
  logic [bmon_pkg::STAT_W-1:0] status_reg;
  logic [bmon_pkg::CELL_W-1:0] cell_count_reg;
  logic [bmon_pkg::LIM_W-1:0]  full_limit;
  logic [bmon_pkg::LIM_W-1:0]  warning_limit;
  logic [bmon_pkg::LIM_W-1:0]  critical_limit;
  logic                        full_flag;

  // Per-sample working registers
  logic [bmon_pkg::VOLT_W-1:0] volt;
  logic [bmon_pkg::LIM_W-1:0]  margin_total;

  // Divider hookup
  bmon_pkg::div_ctrl_t         dctrl;
  bmon_pkg::div_stat_t         dstat;
  logic [bmon_pkg::DIV_DW-1:0] div_num;
  logic [bmon_pkg::DIV_VW-1:0] div_den;
  logic [bmon_pkg::DIV_DW-1:0] div_quot;

  logic                        in_fire;
  logic                        connect;
  logic                        disconnect;
  logic [bmon_pkg::VOLT_W-1:0] volt_sat;
  logic [bmon_pkg::VOLT_W-1:0] cell_quot;
  logic [bmon_pkg::CELL_W-1:0] cells_next;
  logic [bmon_pkg::CMP_W-1:0]  v_x;
  logic [bmon_pkg::CMP_W-1:0]  h_x;
  logic [bmon_pkg::STAT_W-1:0] status_next;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Presence transitions
  assign connect    = (status_reg == bmon_pkg::ST_ABSENT) && (volt > present_threshold);
  assign disconnect = (status_reg != bmon_pkg::ST_ABSENT) && (volt <= present_threshold);

  // Divider operands: voltage scaling on accept, cell count after decide
  always_comb begin
    dctrl.start = 1'b0;
    dctrl.iters = bmon_pkg::ITER_W'(bmon_pkg::DIV_DW);
    div_num     = bmon_pkg::DIV_DW'(raw_sample) * bmon_pkg::DIV_DW'(bmon_pkg::VOLT_SCALE);
    div_den     = FS_DIV;
    if (state == S_DECIDE) begin
      dctrl.start = connect && (cell_max_voltage != '0);
      dctrl.iters = bmon_pkg::ITER_W'(bmon_pkg::VOLT_W);
      div_num     = {volt, {(bmon_pkg::DIV_DW - bmon_pkg::VOLT_W){1'b0}}};
      div_den     = bmon_pkg::DIV_VW'(cell_max_voltage);
    end else if (in_fire) begin
      dctrl.start = 1'b1;
    end
  end

  bmon_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (dctrl),
    .dividend (div_num),
    .divisor  (div_den),
    .quotient (div_quot),
    .stat     (dstat)
  );

  // Voltage saturation and cell count saturation
  assign volt_sat  = (div_quot > bmon_pkg::DIV_DW'(bmon_pkg::VOLT_MAX)) ?
                     bmon_pkg::VOLT_MAX : div_quot[bmon_pkg::VOLT_W-1:0];
  assign cell_quot = div_quot[bmon_pkg::VOLT_W-1:0];
  assign cells_next = (cell_quot >= bmon_pkg::VOLT_W'(MAX_CELLS)) ? CELLS_SAT :
                      (cell_quot[bmon_pkg::CELL_W-1:0] + 1'b1);

  // Hysteresis state machine; "v <= lim - h" is done as "v + h <= lim"
  assign v_x = bmon_pkg::CMP_W'(volt);
  assign h_x = bmon_pkg::CMP_W'(hysteresis);

  always_comb begin
    status_next = status_reg;
    unique case (status_reg)
      bmon_pkg::ST_FULL: begin
        if (v_x + h_x <= bmon_pkg::CMP_W'(full_limit)) status_next = bmon_pkg::ST_OK;
      end
      bmon_pkg::ST_OK: begin
        if (v_x + h_x <= bmon_pkg::CMP_W'(warning_limit))
          status_next = bmon_pkg::ST_WARNING;
        else if (v_x > bmon_pkg::CMP_W'(full_limit) + h_x)
          status_next = bmon_pkg::ST_FULL;
      end
      bmon_pkg::ST_WARNING: begin
        if (v_x + h_x <= bmon_pkg::CMP_W'(critical_limit))
          status_next = bmon_pkg::ST_CRITICAL;
        else if (v_x > bmon_pkg::CMP_W'(warning_limit) + h_x)
          status_next = bmon_pkg::ST_OK;
      end
      bmon_pkg::ST_CRITICAL: begin
        if (v_x > bmon_pkg::CMP_W'(critical_limit) + h_x)
          status_next = bmon_pkg::ST_WARNING;
      end
      default: status_next = status_reg;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_max_voltage     <= bmon_pkg::RST_CELL_MAX;
      cell_warning_voltage <= bmon_pkg::RST_CELL_WARN;
      cell_min_voltage     <= bmon_pkg::RST_CELL_MIN;
      present_threshold    <= bmon_pkg::RST_PRESENT;
      hysteresis           <= bmon_pkg::RST_HYST;
      full_margin_per_cell <= bmon_pkg::RST_MARGIN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bmon_pkg::REG_CELL_MAX:  cell_max_voltage     <= cfg_data[9:0];
        bmon_pkg::REG_CELL_WARN: cell_warning_voltage <= cfg_data[9:0];
        bmon_pkg::REG_CELL_MIN:  cell_min_voltage     <= cfg_data[9:0];
        bmon_pkg::REG_PRESENT:   present_threshold    <= cfg_data[11:0];
        bmon_pkg::REG_HYST:      hysteresis           <= cfg_data[7:0];
        bmon_pkg::REG_MARGIN:    full_margin_per_cell <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Sequencer and state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      status_reg     <= bmon_pkg::ST_ABSENT;
      cell_count_reg <= bmon_pkg::CELL_W'(1);
      full_limit     <= '0;
      warning_limit  <= '0;
      critical_limit <= '0;
      full_flag      <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      // result taken; a new one loaded in S_OUT sets valid instead
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_fire) state <= S_VDIV;
        end
        S_VDIV: begin
          if (dstat.done) begin
            volt  <= volt_sat;
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (connect) begin
            if (cell_max_voltage == '0) begin
              cell_count_reg <= CELLS_SAT;
              state          <= S_LIM;
            end else begin
              state <= S_CDIV;
            end
          end else begin
            if (disconnect) begin
              status_reg     <= bmon_pkg::ST_ABSENT;
              cell_count_reg <= '0;
              warning_limit  <= '0;
              critical_limit <= '0;
            end
            state <= S_EVAL;
          end
        end
        S_CDIV: begin
          if (dstat.done) begin
            cell_count_reg <= cells_next;
            state          <= S_LIM;
          end
        end
        S_LIM: begin
          full_limit     <= bmon_pkg::LIM_W'(cell_count_reg) * bmon_pkg::LIM_W'(cell_max_voltage);
          warning_limit  <= bmon_pkg::LIM_W'(cell_count_reg) *
                            bmon_pkg::LIM_W'(cell_warning_voltage);
          critical_limit <= bmon_pkg::LIM_W'(cell_count_reg) * bmon_pkg::LIM_W'(cell_min_voltage);
          margin_total   <= bmon_pkg::LIM_W'(cell_count_reg) *
                            bmon_pkg::LIM_W'(full_margin_per_cell);
          status_reg     <= bmon_pkg::ST_OK;
          state          <= S_FLAG;
        end
        S_FLAG: begin
          // v >= full - margin, kept unsigned as v + margin >= full
          full_flag <= (v_x + bmon_pkg::CMP_W'(margin_total) >= bmon_pkg::CMP_W'(full_limit));
          state     <= S_EVAL;
        end
        S_EVAL: begin
          status_reg <= status_next;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            battery_voltage <= volt;
            battery_status  <= status_reg;
            cells_detected  <= cell_count_reg;
            full_at_connect <= full_flag;
            out_valid       <= 1'b1;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_start_div: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == S_VDIV)
    else $error("accepted sample did not start the voltage division");

  a_cells_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cells_detected <= CELLS_SAT)
    else $error("cell count above maximum");

  a_done_where: assert property (@(posedge clk) disable iff (rst)
    dstat.done |-> (state == S_VDIV || state == S_CDIV))
    else $error("divider finished outside a wait state");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && !in_fire) |-> !dstat.busy)
    else $error("divider busy while sequencer idle");

endmodule
